// ===== rtl/bvg_pkg.sv =====
// Shared types, constants and curve tables of the battery voltage filter and gauge.
// Depends on nothing; every other file of the block uses it.
package bvg_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned TYPE_W     = 2;
  localparam int unsigned CAL_W      = 12;
  localparam int unsigned VOLT_W     = 12;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned PREC_W     = 19;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 12;

  // Register indexes of the configuration channel.
  localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_TYPE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATION  = 1'b1;

  localparam logic [TYPE_W-1:0] BATTERY_TYPE_RESET = 2'd0;
  localparam logic [CAL_W-1:0]  CALIBRATION_RESET  = 12'd2000;

  localparam logic [SAMPLE_W-1:0] CHARGE_THRESHOLD = 12'd501;
  localparam logic [VOLT_W-1:0]   VOLT_MAX         = 12'd4095;
  localparam logic [PREC_W-1:0]   PRECISE_MAX      = 19'h7FFFF;
  // Smallest coarse quotient whose times-100 value already exceeds PRECISE_MAX.
  localparam logic [12:0]         COARSE_CLAMP     = 13'd5243;
  localparam logic [6:0]          PCT_MAX          = 7'd100;

  // Serial divider geometry.
  localparam int unsigned DIV_NUM_W = 22;
  localparam int unsigned DIV_DEN_W = 12;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [DIV_DEN_W-1:0] AVG_DIVISOR = 12'd7;
  localparam logic [DIV_DEN_W-1:0] SLOPE_SCALE = 12'd1000;

  localparam logic [DIV_CNT_W-1:0] AVG_STEPS  = 5'd12;
  localparam logic [DIV_CNT_W-1:0] VOLT_STEPS = 5'd22;
  localparam logic [DIV_CNT_W-1:0] FRAC_STEPS = 5'd7;
  localparam logic [DIV_CNT_W-1:0] PCT_STEPS  = 5'd11;

  // Discharge curves.
  localparam int unsigned CURVE_POINTS = 11;
  localparam int unsigned CURVE_COUNT  = 3;
  localparam int unsigned CURVE_SEL_W  = $clog2(CURVE_COUNT);
  localparam int unsigned CURVE_V_W    = 10;
  localparam int unsigned SLOPE_W      = 12;
  localparam int unsigned ICPT_W       = 12;

  localparam logic [CURVE_V_W-1:0] CURVE_V [CURVE_COUNT][CURVE_POINTS] = '{
    '{10'd840, 10'd780, 10'd760, 10'd740, 10'd720, 10'd710,
      10'd700, 10'd690, 10'd680, 10'd672, 10'd600},
    '{10'd840, 10'd800, 10'd784, 10'd768, 10'd756, 10'd748,
      10'd742, 10'd738, 10'd732, 10'd720, 10'd600},
    '{10'd840, 10'd762, 10'd744, 10'd726, 10'd710, 10'd690,
      10'd674, 10'd660, 10'd648, 10'd628, 10'd600}
  };

  // Per segment ending at point i: slope (percent per volt times 1000) and
  // intercept, both already truncated the way the gauge defines them.
  // Entry 0 of each row is never used.
  localparam logic [SLOPE_W-1:0] SEG_SLOPE [CURVE_COUNT][CURVE_POINTS] = '{
    '{12'd0, 12'd166, 12'd500, 12'd500, 12'd500, 12'd1000,
      12'd1000, 12'd1000, 12'd1000, 12'd1250, 12'd138},
    '{12'd0, 12'd250, 12'd625, 12'd625, 12'd833, 12'd1250,
      12'd1666, 12'd2500, 12'd1666, 12'd833, 12'd83},
    '{12'd0, 12'd128, 12'd555, 12'd555, 12'd625, 12'd500,
      12'd625, 12'd714, 12'd833, 12'd500, 12'd357}
  };

  localparam logic signed [ICPT_W-1:0] SEG_ICPT [CURVE_COUNT][CURVE_POINTS] = '{
    '{12'sd0, -12'sd39, -12'sd300, -12'sd300, -12'sd300, -12'sd660,
      -12'sd660, -12'sd660, -12'sd660, -12'sd830, -12'sd82},
    '{12'sd0, -12'sd110, -12'sd410, -12'sd410, -12'sd569, -12'sd885,
      -12'sd1196, -12'sd1815, -12'sd1199, -12'sd589, -12'sd49},
    '{12'sd0, -12'sd7, -12'sd332, -12'sd332, -12'sd383, -12'sd295,
      -12'sd381, -12'sd441, -12'sd519, -12'sd304, -12'sd214}
  };

  typedef struct packed {
    logic                     found;
    logic [SLOPE_W-1:0]       slope;
    logic signed [ICPT_W-1:0] icpt;
  } bvg_seg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] rem_init;
    logic [DIV_DEN_W-1:0] den;
    logic [DIV_CNT_W-1:0] steps;
  } bvg_div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
    logic [DIV_DEN_W-1:0] rem;
  } bvg_div_rsp_t;

endpackage

// ===== rtl/bvg_channels.sv =====
// Valid/ready channel interfaces of the battery gauge: sample, result and configuration.
// Depends on bvg_pkg for field widths.
interface bvg_sample_if;
  logic                           valid;
  logic                           ready;
  logic [bvg_pkg::SAMPLE_W-1:0]   voltage_sample;
  logic [bvg_pkg::SAMPLE_W-1:0]   current_sample;

  modport source (output valid, voltage_sample, current_sample, input ready);
  modport sink   (input valid, voltage_sample, current_sample, output ready);
endinterface

interface bvg_result_if;
  logic                         valid;
  logic                         ready;
  logic [bvg_pkg::VOLT_W-1:0]   cal_voltage;
  logic [bvg_pkg::PCT_W-1:0]    percent;
  logic                         charging;
  logic [bvg_pkg::PREC_W-1:0]   precise_voltage;

  modport source (output valid, cal_voltage, percent, charging, precise_voltage,
                  input ready);
  modport sink   (input valid, cal_voltage, percent, charging, precise_voltage,
                  output ready);
endinterface

interface bvg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bvg_pkg::CFG_IDX_W-1:0]   index;
  logic [bvg_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/bvg_serial_div.sv =====
// Bit-serial restoring divider: one quotient bit per clock.
// Depends on bvg_pkg for the request and response structs.
module bvg_serial_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bvg_pkg::bvg_div_req_t req_i,
  output bvg_pkg::bvg_div_rsp_t rsp_o
);
  import bvg_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_NUM_W-1:0] acc_q, acc_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_sub;
  logic                 fits;

  // The numerator is left-aligned in acc; quotient bits enter at the bottom.
  assign rem_sh  = {rem_q, acc_q[DIV_NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign fits    = (rem_sh >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      acc_d  = req_i.num;
      rem_d  = req_i.rem_init;
      den_d  = req_i.den;
    end else if (busy_q) begin
      acc_d = {acc_q[DIV_NUM_W-2:0], fits};
      rem_d = fits ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = acc_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== rtl/bvg_curve_lut.sv =====
// Discharge curve segment lookup: finds the first point below the voltage and
// returns that segment's slope and intercept. Depends on bvg_pkg for the tables.
module bvg_curve_lut (
  input  logic [bvg_pkg::VOLT_W-1:0] volt_i,
  input  logic [bvg_pkg::TYPE_W-1:0] type_i,
  output bvg_pkg::bvg_seg_t          seg_o
);
  import bvg_pkg::*;

  logic [CURVE_SEL_W-1:0] sel;

  // Codes past the last curve fall back to the last curve.
  assign sel = (type_i > TYPE_W'(CURVE_COUNT - 1)) ? CURVE_SEL_W'(CURVE_COUNT - 1)
                                                   : CURVE_SEL_W'(type_i);

  // Walking from the low end upward, the last hit is the first point in
  // curve order whose voltage lies below the input.
  always_comb begin
    seg_o = '0;
    for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
      if (volt_i > VOLT_W'(CURVE_V[sel][i])) begin
        seg_o.found = 1'b1;
        seg_o.slope = SEG_SLOPE[sel][i];
        seg_o.icpt  = SEG_ICPT[sel][i];
      end
    end
  end

endmodule

// ===== rtl/battery_voltage_filter_and_gauge_core.sv =====
// Top level of the battery voltage filter and charge gauge.
// Depends on bvg_pkg, the channel interfaces, bvg_serial_div and bvg_curve_lut.

// Each accepted item carries one battery voltage ADC sample and one charge
// current sample and yields exactly one result item: the calibrated voltage in
// 10 mV units, the charge percentage, the charging flag and the precise
// voltage in 0.1 mV units. The running average is simply reloaded when it is
// zero or the charging state changed, which skips the one-seventh division.
// The block becomes ready for the next item in the same cycle as the result
// becomes valid. All quotients come from the single bit-serial divider, one
// quotient bit per clock while it is busy: 12 bits for the one-seventh step
// of the average, 22 bits for the division by the calibration register, 7
// bits for the fractional refinement of the precise voltage and 11 bits for
// the division by 1000 in the curve interpolation. The block takes a new item
// once the previous result has moved into the output register, so the next
// item can already be in progress while that result is still not taken; if
// the output register is still full when a result is finished, the block
// waits. Configuration writes (battery type, calibration) are accepted in
// every cycle and must only be made while no item is in progress. After
// reset the battery type is 0, the calibration is 2000, the average is zero
// and the gauge assumes charging.
module battery_voltage_filter_and_gauge_core (
  input  logic   clk_i,
  input  logic   rst_ni,
  bvg_sample_if.sink   in_i,
  bvg_result_if.source out_o,
  bvg_cfg_if.sink      cfg_i
);
  import bvg_pkg::*;

  // Sequencer states: each state with a division waits for its done pulse.
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_AVG   = 7'b0000010,
    S_SCALE = 7'b0000100,
    S_VOLT  = 7'b0001000,
    S_FRAC  = 7'b0010000,
    S_PCT   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Configuration and filter state.
  logic [TYPE_W-1:0]   type_q, type_d;
  logic [CAL_W-1:0]    cal_q, cal_d;
  logic [SAMPLE_W-1:0] avg_q, avg_d;
  logic                last_chg_q, last_chg_d;
  logic                out_valid_q, out_valid_d;

  // Per-item working registers.
  logic                chg_q, chg_d;
  logic                neg_q, neg_d;
  logic [VOLT_W-1:0]   volt_q, volt_d;
  logic [12:0]         coarse_q, coarse_d;
  logic [19:0]         base_q, base_d;
  logic [PREC_W-1:0]   prec_q, prec_d;
  logic [PCT_W-1:0]    pct_q, pct_d;
  bvg_seg_t            seg_q, seg;

  // Result register.
  logic [VOLT_W-1:0]   out_volt_q, out_volt_d;
  logic [PCT_W-1:0]    out_pct_q, out_pct_d;
  logic                out_chg_q, out_chg_d;
  logic [PREC_W-1:0]   out_prec_q, out_prec_d;

  bvg_div_req_t        div_req;
  bvg_div_rsp_t        div_rsp;

  // Intermediate values of the datapath.
  logic                in_take;
  logic                chg_new;
  logic [SAMPLE_W-1:0] abs_diff;
  logic [21:0]         scaled;
  logic [18:0]         frac_num;
  logic [23:0]         interp_prod;
  logic [20:0]         prec_sum;
  logic signed [12:0]  pct_s;

  bvg_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  bvg_curve_lut u_lut (
    .volt_i (volt_q),
    .type_i (type_q),
    .seg_o  (seg)
  );

  assign in_take  = in_i.valid && (state_q == S_IDLE);
  assign chg_new  = (in_i.current_sample >= CHARGE_THRESHOLD);
  assign abs_diff = (in_i.voltage_sample > avg_q) ? (in_i.voltage_sample - avg_q)
                                                  : (avg_q - in_i.voltage_sample);

  // average * 760 as 512 + 256 - 8.
  assign scaled = {1'b0, avg_q, 9'b0} + {2'b0, avg_q, 8'b0} - {7'b0, avg_q, 3'b0};

  // Remainder of the coarse division times 100; its quotient by the
  // calibration is below 100, so the top twelve bits preload the remainder.
  assign frac_num = {1'b0, div_rsp.rem, 6'b0} + {2'b0, div_rsp.rem, 5'b0}
                  + {5'b0, div_rsp.rem, 2'b0};

  assign interp_prod = seg_q.slope * volt_q;

  assign prec_sum = {1'b0, base_q} + {14'b0, div_rsp.quo[6:0]};

  assign pct_s = $signed({2'b00, div_rsp.quo[10:0]})
               + $signed({seg_q.icpt[ICPT_W-1], seg_q.icpt});

  always_comb begin
    state_d     = state_q;
    type_d      = type_q;
    cal_d       = cal_q;
    avg_d       = avg_q;
    last_chg_d  = last_chg_q;
    out_valid_d = out_valid_q;
    chg_d       = chg_q;
    neg_d       = neg_q;
    volt_d      = volt_q;
    coarse_d    = coarse_q;
    base_d      = base_q;
    prec_d      = prec_q;
    pct_d       = pct_q;
    out_volt_d  = out_volt_q;
    out_pct_d   = out_pct_q;
    out_chg_d   = out_chg_q;
    out_prec_d  = out_prec_q;
    div_req     = '0;

    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_BATTERY_TYPE: type_d = cfg_i.data[TYPE_W-1:0];
        CFG_CALIBRATION:  cal_d  = cfg_i.data[CAL_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          chg_d      = chg_new;
          last_chg_d = chg_new;
          if ((avg_q == '0) || (chg_new != last_chg_q)) begin
            avg_d   = in_i.voltage_sample;
            state_d = S_SCALE;
          end else begin
            // Truncating division of the signed difference: divide the
            // magnitude and apply the sign when the quotient comes back.
            neg_d            = (in_i.voltage_sample > avg_q);
            div_req.start    = 1'b1;
            div_req.num      = {abs_diff, 10'b0};
            div_req.rem_init = '0;
            div_req.den      = AVG_DIVISOR;
            div_req.steps    = AVG_STEPS;
            state_d          = S_AVG;
          end
        end
      end
      S_AVG: begin
        if (div_rsp.done) begin
          avg_d   = neg_q ? (avg_q + div_rsp.quo[SAMPLE_W-1:0])
                          : (avg_q - div_rsp.quo[SAMPLE_W-1:0]);
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        div_req.start    = 1'b1;
        div_req.num      = scaled;
        div_req.rem_init = '0;
        div_req.den      = cal_q;
        div_req.steps    = VOLT_STEPS;
        state_d          = S_VOLT;
      end
      S_VOLT: begin
        if (div_rsp.done) begin
          // A zero calibration yields an all-ones quotient, which saturates
          // both voltages.
          volt_d   = (div_rsp.quo[21:12] != '0) ? VOLT_MAX : div_rsp.quo[VOLT_W-1:0];
          coarse_d = (div_rsp.quo >= 22'(COARSE_CLAMP)) ? COARSE_CLAMP
                                                        : div_rsp.quo[12:0];
          div_req.start    = 1'b1;
          div_req.num      = {frac_num[6:0], 15'b0};
          div_req.rem_init = frac_num[18:7];
          div_req.den      = cal_q;
          div_req.steps    = FRAC_STEPS;
          state_d          = S_FRAC;
        end
      end
      S_FRAC: begin
        base_d = {1'b0, coarse_q, 6'b0} + {2'b0, coarse_q, 5'b0} + {5'b0, coarse_q, 2'b0};
        if (div_rsp.done) begin
          prec_d = (prec_sum > 21'(PRECISE_MAX)) ? PRECISE_MAX : prec_sum[PREC_W-1:0];
          // The product stays below 1000 * 2048, so its top ten bits preload
          // the remainder and eleven quotient bits remain.
          div_req.start    = 1'b1;
          div_req.num      = {interp_prod[10:0], 11'b0};
          div_req.rem_init = {2'b00, interp_prod[20:11]};
          div_req.den      = SLOPE_SCALE;
          div_req.steps    = PCT_STEPS;
          state_d          = S_PCT;
        end
      end
      S_PCT: begin
        if (div_rsp.done) begin
          if (!seg_q.found || (pct_s < 13'sd0)) begin
            pct_d = '0;
          end else if (pct_s > 13'sd100) begin
            pct_d = PCT_MAX;
          end else begin
            pct_d = pct_s[PCT_W-1:0];
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_volt_d  = volt_q;
          out_pct_d   = pct_q;
          out_chg_d   = chg_q;
          out_prec_d  = prec_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      type_q      <= BATTERY_TYPE_RESET;
      cal_q       <= CALIBRATION_RESET;
      avg_q       <= '0;
      last_chg_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      type_q      <= type_d;
      cal_q       <= cal_d;
      avg_q       <= avg_d;
      last_chg_q  <= last_chg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chg_q      <= chg_d;
    neg_q      <= neg_d;
    volt_q     <= volt_d;
    coarse_q   <= coarse_d;
    base_q     <= base_d;
    prec_q     <= prec_d;
    pct_q      <= pct_d;
    seg_q      <= seg;
    out_volt_q <= out_volt_d;
    out_pct_q  <= out_pct_d;
    out_chg_q  <= out_chg_d;
    out_prec_q <= out_prec_d;
  end

  assign in_i.ready            = (state_q == S_IDLE);
  assign cfg_i.ready           = 1'b1;
  assign out_o.valid           = out_valid_q;
  assign out_o.cal_voltage     = out_volt_q;
  assign out_o.percent         = out_pct_q;
  assign out_o.charging        = out_chg_q;
  assign out_o.precise_voltage = out_prec_q;

endmodule
